### design/ewma_ads_pkg.sv
// Package for the per-agent, per-domain moving-average statistics table.
// Holds the Q1.16 constants, the ground-truth codes, the parameter defaults
// and the blend function. It depends on nothing else.
`default_nettype none

package ewma_ads_pkg;

    // Parameter defaults for the top level.
    localparam int MAX_AGENTS_DEFAULT   = 16;
    localparam int DOMAIN_COUNT_DEFAULT = 8;

    // Reset value of the agent count register.
    localparam logic [4:0] AGENT_COUNT_RESET = 5'd16;

    // Q1.16 constants, 65536 standing for 1.0.
    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;

    // Ground-truth codes; both remaining codes mean unknown.
    localparam logic [1:0] GT_INCORRECT = 2'd0;
    localparam logic [1:0] GT_CORRECT   = 2'd1;
    localparam logic [1:0] GT_UNKNOWN   = 2'd2;

    // ceil(2^22 / 5): multiplying by this and dropping 22 bits divides
    // any 19-bit value by five exactly.
    localparam logic [19:0] RECIP_5       = 20'd838861;
    localparam int          RECIP_5_SHIFT = 22;

    // Control fields of one item between acceptance and the blend stage.
    typedef struct packed {
        logic        upd;          // the item updates the tables
        logic [3:0]  agent;        // agent whose entry is updated
        logic [16:0] sample;       // clipped sigma sample, or one half
        logic        acc_known;    // ground truth applies
        logic        acc_correct;  // ground truth says correct
        logic        last;         // copy of the batch end mark
    } item_ctl_t;

    // new = floor((19*old + sample + 10) / 20), i.e. 0.95*old + 0.05*sample
    // rounded to nearest. The division by 20 is a shift by two followed by
    // a reciprocal multiplication for the division by five.
    function automatic logic [16:0] blend(input logic [16:0] old_val,
                                          input logic [16:0] sample_val);
        logic [20:0] sum;
        logic [18:0] quarter;
        logic [38:0] prod;
        sum     = 21'(old_val) * 21'd19 + 21'(sample_val) + 21'd10;
        quarter = sum[20:2];
        prod    = 39'(quarter) * 39'(RECIP_5);
        return prod[RECIP_5_SHIFT+16:RECIP_5_SHIFT];
    endfunction

endpackage

`default_nettype wire

### design/ewma_agent_domain_stats_table.sv
// A beat accepted is held in the blend stage registers, then in the result registers.
// Throughput: one beat per cycle while results are taken; the read-modify-write of the
// two table entries and the request counter is closed by forwarding the most recent
// write into the blend stage. Reset: synchronous, active low. A clearing pass then
// zeroes the tables, one entry a cycle; no beat is taken meanwhile.
`default_nettype none

module ewma_agent_domain_stats_table
    import ewma_ads_pkg::*;
#(
    parameter int MAX_AGENTS   = MAX_AGENTS_DEFAULT,
    parameter int DOMAIN_COUNT = DOMAIN_COUNT_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    // Configuration write channel: the agent count register.
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [4:0]         cfg_data,

    // Response beats.
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [3:0]         s_agent_index,
    input  wire logic signed [17:0] s_reported_sigma,
    input  wire logic [3:0]         s_domain,
    input  wire logic [3:0]         s_winner_index,
    input  wire logic [1:0]         s_ground_truth,
    input  wire logic               s_winner_mode,
    input  wire logic               s_batch_last,

    // Result beats.
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_updated,
    output logic [3:0]              m_updated_agent,
    output logic [16:0]             m_new_sigma,
    output logic [16:0]             m_new_accuracy,
    output logic [31:0]             m_request_total,
    output logic                    m_result_last
);

    // Table depth and index widths. A width never drops below one bit.
    localparam int TABLE_DEPTH = MAX_AGENTS * DOMAIN_COUNT;
    localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam logic [TW-1:0] LAST_KEY = TW'(TABLE_DEPTH - 1);

    // The three stores. Sigma and accuracy share one address.
    logic [16:0] sigma_mem    [TABLE_DEPTH];
    logic [16:0] accuracy_mem [TABLE_DEPTH];
    logic [31:0] count_mem    [MAX_AGENTS];

    // Control state.
    logic [4:0]    agent_count_reg;
    logic          winner_matched_reg;
    logic          clr_active_reg;
    logic [TW-1:0] clr_cnt_reg;
    logic          st_valid_reg;
    logic          m_valid_reg;
    logic          fwd_valid_reg;

    // Blend stage registers and the registered read data.
    item_ctl_t     st_ctl_reg;
    logic [TW-1:0] st_key_reg;
    logic [16:0]   rd_sigma_reg;
    logic [16:0]   rd_accuracy_reg;
    logic [31:0]   rd_count_reg;

    // The most recent write to the tables, for forwarding.
    logic [TW-1:0] fwd_key_reg;
    logic [AW-1:0] fwd_agent_reg;
    logic [16:0]   fwd_sigma_reg;
    logic [16:0]   fwd_accuracy_reg;
    logic [31:0]   fwd_count_reg;

    // Result payload registers.
    logic          m_updated_reg;
    logic [3:0]    m_updated_agent_reg;
    logic [16:0]   m_new_sigma_reg;
    logic [16:0]   m_new_accuracy_reg;
    logic [31:0]   m_request_total_reg;
    logic          m_result_last_reg;

    // Handshake decisions.
    logic in_accept;
    logic st_advance;

    // Decision taken for a beat as it is accepted.
    item_ctl_t     st_ctl_next;
    logic [TW-1:0] st_key_next;
    logic [AW-1:0] rd_agent_next;
    logic          winner_matched_next;

    // Blend stage values.
    logic [AW-1:0] st_agent_idx;
    logic [16:0]   old_sigma;
    logic [16:0]   old_accuracy;
    logic [31:0]   old_count;
    logic [16:0]   new_sigma;
    logic [16:0]   new_accuracy;
    logic [31:0]   new_count;
    logic          tbl_write;

    // ------------------------------------------------------------------
    // Handshakes. The blend stage moves on whenever the result register is
    // empty or being emptied, so beats flow at one per cycle while results
    // are taken, and one more beat can still enter while a result waits.
    // ------------------------------------------------------------------
    assign cfg_ready  = 1'b1;
    assign st_advance = st_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !clr_active_reg && (!st_valid_reg || st_advance);
    assign in_accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Acceptance: clip the sigma and decide whether, and for which agent,
    // the beat updates the tables. The winner-matched flag only changes
    // here, so it is always current for the beat at the port.
    // ------------------------------------------------------------------
    always_comb begin
        logic [16:0] clipped;
        logic        win_ok;
        logic        agent_ok;
        logic        dom_ok;
        logic        gt_known;

        if (s_reported_sigma[17]) begin
            clipped = 17'd0;
        end else if (s_reported_sigma[16:0] > ONE_Q16) begin
            clipped = ONE_Q16;
        end else begin
            clipped = s_reported_sigma[16:0];
        end

        win_ok   = ({1'b0, s_winner_index} < agent_count_reg)
                   && (32'(s_winner_index) < MAX_AGENTS);
        agent_ok = ({1'b0, s_agent_index} < agent_count_reg)
                   && (32'(s_agent_index) < MAX_AGENTS);
        dom_ok   = 32'(s_domain) < DOMAIN_COUNT;
        gt_known = (s_ground_truth == GT_INCORRECT) || (s_ground_truth == GT_CORRECT);

        st_ctl_next.upd         = 1'b0;
        st_ctl_next.agent       = s_agent_index;
        st_ctl_next.sample      = clipped;
        st_ctl_next.acc_known   = gt_known;
        st_ctl_next.acc_correct = (s_ground_truth == GT_CORRECT);
        st_ctl_next.last        = s_batch_last;
        winner_matched_next     = winner_matched_reg;

        if (s_winner_mode) begin
            // Only the winner is ever updated, and ground truth applies to it directly.
            st_ctl_next.agent = s_winner_index;
            if (win_ok) begin
                if ((s_agent_index == s_winner_index) && !winner_matched_reg) begin
                    st_ctl_next.upd     = dom_ok;
                    winner_matched_next = 1'b1;
                end else if (s_batch_last && !winner_matched_reg) begin
                    // Nobody matched in this batch: the winner takes one half.
                    st_ctl_next.upd    = dom_ok;
                    st_ctl_next.sample = HALF_Q16;
                end
            end
        end else begin
            // Ground truth only counts for the winner's own response.
            st_ctl_next.upd       = agent_ok && dom_ok;
            st_ctl_next.acc_known = gt_known && (s_agent_index == s_winner_index);
        end

        if (s_batch_last) begin
            winner_matched_next = 1'b0;
        end

        rd_agent_next = AW'(st_ctl_next.agent);
        st_key_next   = TW'(rd_agent_next) * TW'(DOMAIN_COUNT) + TW'(s_domain);
    end

    // ------------------------------------------------------------------
    // Blend stage. The registered read data may miss the write made at the
    // edge of the read, so the most recent write is forwarded on a match.
    // The forwarding registers always agree with the store or are newer.
    // ------------------------------------------------------------------
    always_comb begin
        st_agent_idx = AW'(st_ctl_reg.agent);

        if (fwd_valid_reg && (fwd_key_reg == st_key_reg)) begin
            old_sigma    = fwd_sigma_reg;
            old_accuracy = fwd_accuracy_reg;
        end else begin
            old_sigma    = rd_sigma_reg;
            old_accuracy = rd_accuracy_reg;
        end

        if (fwd_valid_reg && (fwd_agent_reg == st_agent_idx)) begin
            old_count = fwd_count_reg;
        end else begin
            old_count = rd_count_reg;
        end

        new_sigma = blend(old_sigma, st_ctl_reg.sample);
        if (st_ctl_reg.acc_known) begin
            new_accuracy = blend(old_accuracy, st_ctl_reg.acc_correct ? ONE_Q16 : 17'd0);
        end else begin
            new_accuracy = old_accuracy;
        end
        new_count = old_count + 32'd1;

        tbl_write = st_advance && st_ctl_reg.upd;
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            agent_count_reg    <= AGENT_COUNT_RESET;
            winner_matched_reg <= 1'b0;
            clr_active_reg     <= 1'b1;
            clr_cnt_reg        <= '0;
            st_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
            fwd_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                agent_count_reg <= cfg_data;
            end

            if (clr_active_reg) begin
                if (clr_cnt_reg == LAST_KEY) begin
                    clr_active_reg <= 1'b0;
                end else begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
            end

            if (in_accept) begin
                winner_matched_reg <= winner_matched_next;
            end

            if (in_accept) begin
                st_valid_reg <= 1'b1;
            end else if (st_advance) begin
                st_valid_reg <= 1'b0;
            end

            if (st_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (tbl_write) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: the blend stage, the forwarding copy and the result.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            st_ctl_reg <= st_ctl_next;
            st_key_reg <= st_key_next;
        end

        if (tbl_write) begin
            fwd_key_reg      <= st_key_reg;
            fwd_agent_reg    <= st_agent_idx;
            fwd_sigma_reg    <= new_sigma;
            fwd_accuracy_reg <= new_accuracy;
            fwd_count_reg    <= new_count;
        end

        if (st_advance) begin
            m_result_last_reg <= st_ctl_reg.last;
            if (st_ctl_reg.upd) begin
                m_updated_reg       <= 1'b1;
                m_updated_agent_reg <= st_ctl_reg.agent;
                m_new_sigma_reg     <= new_sigma;
                m_new_accuracy_reg  <= new_accuracy;
                m_request_total_reg <= new_count;
            end else begin
                m_updated_reg       <= 1'b0;
                m_updated_agent_reg <= 4'd0;
                m_new_sigma_reg     <= 17'd0;
                m_new_accuracy_reg  <= 17'd0;
                m_request_total_reg <= 32'd0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stores. Reads happen at acceptance into registers; the single write
    // port is shared by the clearing pass and the blend stage, which never
    // overlap because no beat is taken while the pass runs.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_sigma_reg    <= sigma_mem[st_key_next];
            rd_accuracy_reg <= accuracy_mem[st_key_next];
            rd_count_reg    <= count_mem[rd_agent_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            sigma_mem[clr_cnt_reg]    <= 17'd0;
            accuracy_mem[clr_cnt_reg] <= 17'd0;
            if (32'(clr_cnt_reg) < MAX_AGENTS) begin
                count_mem[AW'(clr_cnt_reg)] <= 32'd0;
            end
        end else if (tbl_write) begin
            sigma_mem[st_key_reg]    <= new_sigma;
            accuracy_mem[st_key_reg] <= new_accuracy;
            count_mem[st_agent_idx]  <= new_count;
        end
    end

    // Outputs.
    assign m_valid         = m_valid_reg;
    assign m_updated       = m_updated_reg;
    assign m_updated_agent = m_updated_agent_reg;
    assign m_new_sigma     = m_new_sigma_reg;
    assign m_new_accuracy  = m_new_accuracy_reg;
    assign m_request_total = m_request_total_reg;
    assign m_result_last   = m_result_last_reg;

endmodule

`default_nettype wire

### tb/ewma_stats_checker.sv
// Checker for the per-agent, per-domain moving-average statistics table.
// Watches the configuration, response and result channels, keeps its own copy of the tables,
// and compares every result beat. Depends on ewma_ads_pkg.
module ewma_stats_checker
    import ewma_ads_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [4:0]         cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [3:0]         s_agent_index,
    input  logic signed [17:0] s_reported_sigma,
    input  logic [3:0]         s_domain,
    input  logic [3:0]         s_winner_index,
    input  logic [1:0]         s_ground_truth,
    input  logic               s_winner_mode,
    input  logic               s_batch_last,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_updated,
    input  logic [3:0]         m_updated_agent,
    input  logic [16:0]        m_new_sigma,
    input  logic [16:0]        m_new_accuracy,
    input  logic [31:0]        m_request_total,
    input  logic               m_result_last,
    output int                 mismatches,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = MAX_AGENTS_DEFAULT * DOMAIN_COUNT_DEFAULT;

    typedef struct packed {
        logic        updated;
        logic [3:0]  agent;
        logic [16:0] sigma_avg;
        logic [16:0] accuracy_avg;
        logic [31:0] requests;
        logic        last;
    } stats_result_t;

    logic [16:0]   sigma_avg [ENTRIES];
    logic [16:0]   accuracy_avg [ENTRIES];
    logic [31:0]   request_count [MAX_AGENTS_DEFAULT];
    logic          winner_seen;
    logic [4:0]    agents_in_use;
    stats_result_t awaited_results [$];

    // 0.95*old + 0.05*sample, rounded to nearest with halves going up.
    function automatic logic [16:0] ewma_blend(input logic [16:0] prev,
                                               input logic [16:0] sample);
        int unsigned acc;
        acc = 19 * int'(prev) + int'(sample) + 10;
        return 17'(acc / 20);
    endfunction

    function automatic logic agent_in_use(input logic [3:0] a);
        return int'(a) < int'(agents_in_use) && int'(a) < MAX_AGENTS_DEFAULT;
    endfunction

    // Blends one sample into an entry and bumps the agent's request count.
    function automatic stats_result_t learn_entry(input logic [3:0] a, input logic [3:0] dom,
                                                  input logic [16:0] sample,
                                                  input logic [1:0] gt, input logic last);
        stats_result_t r;
        int k;
        r = '0;
        r.last = last;
        if (int'(dom) >= DOMAIN_COUNT_DEFAULT)
            return r;
        k = int'(a) * DOMAIN_COUNT_DEFAULT + int'(dom);
        sigma_avg[k] = ewma_blend(sigma_avg[k], sample);
        if (gt == GT_CORRECT)
            accuracy_avg[k] = ewma_blend(accuracy_avg[k], ONE_Q16);
        else if (gt == GT_INCORRECT)
            accuracy_avg[k] = ewma_blend(accuracy_avg[k], '0);
        request_count[a] = request_count[a] + 32'd1;
        r.updated      = 1'b1;
        r.agent        = a;
        r.sigma_avg    = sigma_avg[k];
        r.accuracy_avg = accuracy_avg[k];
        r.requests     = request_count[a];
        return r;
    endfunction

    function automatic stats_result_t predict_response(input logic [3:0] agent,
                                                       input logic signed [17:0] sigma,
                                                       input logic [3:0] dom,
                                                       input logic [3:0] win,
                                                       input logic [1:0] gt,
                                                       input logic wo, input logic last);
        stats_result_t r;
        logic [16:0]   sample;
        r = '0;
        r.last = last;
        if (sigma < 0)
            sample = '0;
        else if (sigma > 18'sd65536)
            sample = ONE_Q16;
        else
            sample = 17'(sigma);

        if (wo) begin
            // Only the winner learns, from its own first beat of the batch, or from a
            // neutral half at the batch end when it never spoke.
            if (agent_in_use(win)) begin
                if (agent == win && !winner_seen) begin
                    r = learn_entry(win, dom, sample, gt, last);
                    winner_seen = 1'b1;
                end else if (last && !winner_seen) begin
                    r = learn_entry(win, dom, HALF_Q16, gt, last);
                end
            end
        end else if (agent_in_use(agent)) begin
            r = learn_entry(agent, dom, sample, (agent == win) ? gt : GT_UNKNOWN, last);
        end

        if (last)
            winner_seen = 1'b0;
        return r;
    endfunction

    task automatic compare_field(input string field, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s differs, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        stats_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                sigma_avg[i]    = '0;
                accuracy_avg[i] = '0;
            end
            for (int i = 0; i < MAX_AGENTS_DEFAULT; i++)
                request_count[i] = '0;
            winner_seen   = 1'b0;
            agents_in_use = AGENT_COUNT_RESET;
            awaited_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                agents_in_use = cfg_data;
            if (s_valid && s_ready)
                awaited_results.push_back(predict_response(s_agent_index, s_reported_sigma,
                    s_domain, s_winner_index, s_ground_truth, s_winner_mode, s_batch_last));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, %s %0d sigma %0d",
                             $time, "expected none, actual agent", m_updated_agent,
                             m_new_sigma);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("updated", 64'(want.updated), 64'(m_updated));
                    compare_field("updated_agent", 64'(want.agent), 64'(m_updated_agent));
                    compare_field("new_sigma", 64'(want.sigma_avg), 64'(m_new_sigma));
                    compare_field("new_accuracy", 64'(want.accuracy_avg),
                                  64'(m_new_accuracy));
                    compare_field("request_total", 64'(want.requests),
                                  64'(m_request_total));
                    compare_field("result_last", 64'(want.last), 64'(m_result_last));
                end
            end
        end
        outstanding <= awaited_results.size();
    end

endmodule

### tb/tb.sv
// Top of the testbench for the moving-average statistics table: clock, reset and stimulus.
// Instantiates the table and the ewma_stats_checker beside it, and gives the final verdict.
// Depends on ewma_ads_pkg, the table RTL and tb/ewma_stats_checker.sv.
module tb;
    import ewma_ads_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Mode and batch marks, and the second ground-truth code that means unknown.
    localparam logic       NORMAL_MODE = 1'b0;
    localparam logic       WINNER_MODE = 1'b1;
    localparam logic       MID_BATCH   = 1'b0;
    localparam logic       BATCH_END   = 1'b1;
    localparam logic [1:0] GT_SPARE    = 2'd3;

    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 6;
    localparam int RUN_LIMIT_NS     = 3_000_000;

    logic               aclk             = 1'b0;
    logic               aresetn          = 1'b0;
    logic               cfg_valid        = 1'b0;
    logic               cfg_ready;
    logic [4:0]         cfg_data         = '0;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic [3:0]         s_agent_index    = '0;
    logic signed [17:0] s_reported_sigma = '0;
    logic [3:0]         s_domain         = '0;
    logic [3:0]         s_winner_index   = '0;
    logic [1:0]         s_ground_truth   = '0;
    logic               s_winner_mode    = 1'b0;
    logic               s_batch_last     = 1'b0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic               m_updated;
    logic [3:0]         m_updated_agent;
    logic [16:0]        m_new_sigma;
    logic [16:0]        m_new_accuracy;
    logic [31:0]        m_request_total;
    logic               m_result_last;

    int mismatches;
    int outstanding;

    // Chance in percent that either side starts an idle burst; zero means a steady stream.
    int idle_pct  = 20;
    // Each increment asks the receiver for one long hold-off.
    int hold_asks = 0;

    ewma_agent_domain_stats_table i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_agent_index    (s_agent_index),
        .s_reported_sigma (s_reported_sigma),
        .s_domain         (s_domain),
        .s_winner_index   (s_winner_index),
        .s_ground_truth   (s_ground_truth),
        .s_winner_mode    (s_winner_mode),
        .s_batch_last     (s_batch_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_updated        (m_updated),
        .m_updated_agent  (m_updated_agent),
        .m_new_sigma      (m_new_sigma),
        .m_new_accuracy   (m_new_accuracy),
        .m_request_total  (m_request_total),
        .m_result_last    (m_result_last)
    );

    ewma_stats_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_agent_index    (s_agent_index),
        .s_reported_sigma (s_reported_sigma),
        .s_domain         (s_domain),
        .s_winner_index   (s_winner_index),
        .s_ground_truth   (s_ground_truth),
        .s_winner_mode    (s_winner_mode),
        .s_batch_last     (s_batch_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_updated        (m_updated),
        .m_updated_agent  (m_updated_agent),
        .m_new_sigma      (m_new_sigma),
        .m_new_accuracy   (m_new_accuracy),
        .m_request_total  (m_request_total),
        .m_result_last    (m_result_last),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    always #5 aclk = ~aclk;

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial begin
        #RUN_LIMIT_NS;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side. Every loop pass makes exactly one assignment to m_ready at the current
    // edge and then moves time on, so ready never glitches within a time step. A long
    // hold-off, when asked for, is counted here in cycles while the sender keeps offering.
    initial begin : receiver
        int holds_served;
        holds_served = 0;
        @(posedge aclk);
        forever begin
            if (holds_served < hold_asks) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Offers one response beat and returns at the edge where it is taken. An idle burst
    // may come first; valid is only lowered when such a burst really happens, so a
    // back-to-back stream keeps valid high without a drop in the same step.
    task automatic offer(input logic [3:0] agent, input logic signed [17:0] sigma,
                         input logic [3:0] dom, input logic [3:0] win, input logic [1:0] gt,
                         input logic wo, input logic last);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_agent_index    <= agent;
        s_reported_sigma <= sigma;
        s_domain         <= dom;
        s_winner_index   <= win;
        s_ground_truth   <= gt;
        s_winner_mode    <= wo;
        s_batch_last     <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Writes the agent count. Only called with the block idle.
    task automatic write_agent_count(input logic [4:0] count);
        cfg_data  <= count;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering and waits until every expected result beat has come back, then lets
    // the block settle so that nothing is still in flight.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Sigma mix: the usable range, its exact corners, values above one, negatives, and
    // anything at all.
    function automatic logic signed [17:0] random_sigma();
        logic signed [17:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = 18'($urandom_range(0, 65536));
            2: begin
                case ($urandom_range(0, 4))
                    0: v = 18'sd0;
                    1: v = 18'sd1;
                    2: v = 18'sd32768;
                    3: v = 18'sd65535;
                    default: v = 18'sd65536;
                endcase
            end
            3: v = 18'($urandom_range(65537, 131071));
            4: v = 18'(-int'($urandom_range(1, 131072)));
            default: v = 18'($urandom);
        endcase
        return v;
    endfunction

    // One batch with a shared domain and winner. Most batches are well formed, ending on
    // a single last beat; about one in ten has its last marks scattered at random.
    task automatic send_batch(input int agents, inout int sent);
        int         n_valid;
        int         len;
        logic [3:0] dom;
        logic [3:0] win;
        logic [3:0] agent;
        logic       wo;
        logic       broken;
        logic       last;
        n_valid = (agents == 0) ? 1 : ((agents > MAX_AGENTS_DEFAULT) ? MAX_AGENTS_DEFAULT : agents);
        len     = $urandom_range(1, 6);
        dom     = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, DOMAIN_COUNT_DEFAULT - 1))
                                               : 4'($urandom_range(DOMAIN_COUNT_DEFAULT, 15));
        win     = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, n_valid - 1))
                                               : 4'($urandom_range(0, 15));
        wo      = 1'($urandom_range(0, 1));
        broken  = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < (wo ? 35 : 25))
                agent = win;
            else if ($urandom_range(0, 99) < 80)
                agent = 4'($urandom_range(0, n_valid - 1));
            else
                agent = 4'($urandom_range(0, 15));
            last = broken ? 1'($urandom_range(0, 1)) : (i == len - 1);
            offer(agent, random_sigma(), dom, win, 2'($urandom_range(0, 3)), wo, last);
            sent++;
        end
    endtask

    // Random traffic for one configuration: mostly batches, with some stray beats whose
    // every field is drawn from its whole range.
    task automatic run_phase(input int beats, input int agents);
        int sent;
        sent = 0;
        while (sent < beats) begin
            if ($urandom_range(0, 99) < 8) begin
                offer(4'($urandom), 18'($urandom), 4'($urandom), 4'($urandom),
                      2'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end else begin
                send_batch(agents, sent);
            end
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // The block clears its tables after reset; the first response beat simply waits
        // for ready, so no beat goes in until the clearing pass is done.
        write_agent_count(5'd16);

        // Directed part, all sixteen agents in use.
        offer(4'd0, 18'sd0, 4'd0, 4'd0, GT_CORRECT, NORMAL_MODE, BATCH_END);
        offer(4'd15, 18'sd65536, 4'd7, 4'd15, GT_INCORRECT, NORMAL_MODE, BATCH_END);
        // Same entry again straight away, so the blend has to see the previous write.
        offer(4'd15, 18'sd65536, 4'd7, 4'd15, GT_CORRECT, NORMAL_MODE, BATCH_END);
        // Sigma just above one is clipped; the largest positive code as well.
        offer(4'd3, 18'sd65537, 4'd2, 4'd3, GT_UNKNOWN, NORMAL_MODE, BATCH_END);
        // Ground truth is ignored when the agent is not the winner.
        offer(4'd3, 18'sd131071, 4'd2, 4'd4, GT_CORRECT, NORMAL_MODE, BATCH_END);
        // Negative sigma counts as zero; the spare code means unknown.
        offer(4'd5, 18'(-1), 4'd1, 4'd5, GT_SPARE, NORMAL_MODE, BATCH_END);
        offer(4'd5, 18'(-131072), 4'd1, 4'd5, GT_CORRECT, NORMAL_MODE, BATCH_END);
        // Domains out of range make no update.
        offer(4'd6, 18'sd40000, 4'd8, 4'd6, GT_CORRECT, NORMAL_MODE, BATCH_END);
        offer(4'd6, 18'sd40000, 4'd15, 4'd6, GT_CORRECT, NORMAL_MODE, BATCH_END);
        // Winner-only batch: only the first beat from the winner counts, and no neutral
        // update follows at the end because the winner has already spoken.
        offer(4'd2, 18'sd1000, 4'd3, 4'd6, GT_CORRECT, WINNER_MODE, MID_BATCH);
        offer(4'd6, 18'sd50000, 4'd3, 4'd6, GT_CORRECT, WINNER_MODE, MID_BATCH);
        offer(4'd6, 18'sd9000, 4'd3, 4'd6, GT_INCORRECT, WINNER_MODE, MID_BATCH);
        offer(4'd1, 18'sd9000, 4'd3, 4'd6, GT_INCORRECT, WINNER_MODE, BATCH_END);
        // Winner never speaks: the last beat gives the winner a neutral half.
        offer(4'd1, 18'sd12345, 4'd4, 4'd9, GT_UNKNOWN, WINNER_MODE, MID_BATCH);
        offer(4'd2, 18'sd23456, 4'd4, 4'd9, GT_CORRECT, WINNER_MODE, BATCH_END);
        // Winner speaks on the last beat itself.
        offer(4'd4, 18'sd65536, 4'd5, 4'd4, GT_INCORRECT, WINNER_MODE, BATCH_END);
        // A winner match on a bad domain updates nothing but still counts as the match.
        offer(4'd7, 18'sd30000, 4'd12, 4'd7, GT_CORRECT, WINNER_MODE, MID_BATCH);
        offer(4'd0, 18'sd30000, 4'd1, 4'd7, GT_CORRECT, WINNER_MODE, BATCH_END);
        drain_results();

        // Five agents: the edge between valid and invalid agents and winners.
        write_agent_count(5'd5);
        offer(4'd9, 18'sd100, 4'd0, 4'd9, GT_CORRECT, WINNER_MODE, BATCH_END);
        offer(4'd9, 18'sd100, 4'd0, 4'd9, GT_CORRECT, NORMAL_MODE, BATCH_END);
        offer(4'd4, 18'sd100, 4'd0, 4'd4, GT_CORRECT, NORMAL_MODE, BATCH_END);
        offer(4'd5, 18'sd100, 4'd0, 4'd5, GT_CORRECT, NORMAL_MODE, BATCH_END);
        run_phase(200, 5);
        drain_results();

        // A single agent, so the same few entries are hit over and over.
        write_agent_count(5'd1);
        idle_pct = 35;
        run_phase(150, 1);
        drain_results();

        // The register may exceed the table size; it then behaves as sixteen.
        write_agent_count(5'd31);
        idle_pct = 10;
        run_phase(100, 31);
        drain_results();

        // No agent in use: every beat comes back without an update.
        write_agent_count(5'd0);
        run_phase(40, 0);
        drain_results();

        write_agent_count(5'd12);
        idle_pct = 25;
        run_phase(250, 12);
        drain_results();

        // Steady stream, then a long receiver hold-off while beats keep coming, so the
        // block fills and stalls its input. Then the sender waits for everything to
        // come back before carrying on.
        write_agent_count(5'd16);
        idle_pct = 0;
        run_phase(100, 16);
        hold_asks++;
        run_phase(150, 16);
        drain_results();
        idle_pct = 15;
        run_phase(150, 16);
        drain_results();

        write_agent_count(5'd3);
        idle_pct = 30;
        run_phase(200, 3);
        drain_results();

        // Last stretch at full rate with no idling on either side.
        write_agent_count(5'd16);
        idle_pct = 0;
        run_phase(250, 16);
        drain_results();
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
